/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hwrp_pkg.sv */
package hwrp_pkg;

    localparam int ADDR_BITS  = 6;
    localparam int SLOT_COUNT = 64;

    localparam int HIT_W   = 112;
    localparam int UPPER_W = 48;
    localparam int LOWER_W = 64;
    localparam int WORD_W  = 32;
    localparam int TAG_W   = 8;
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 11;
    localparam int OFF_W   = 11;

    localparam logic [WORD_W-1:0] END_WORD = 32'hFFFF_FFFF;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [HIT_W-1:0]     t_hit;

    // Request from the walk control to the hit store.
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        logic  rd_en;
        t_addr rd_addr;
    } t_store_req;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

endpackage

/* sv/hit_window_readout_packer_top.sv */
// Channel  | Direction | Handshake              | Payload
// in       | input     | i_in_valid / o_in_stall | action, slot, hit, window times
// out      | output    | o_out_valid / i_out_stall | five words, last
// cfg      | input     | i_cfg_valid / o_cfg_ready | segment tag
//
// A trigger walks one slot per cycle, while the output does not stall, through the
// store's single read port, and holds the input until the walk and its closing item
// are done; an empty window yields only the closing item.
// The next input transaction is taken once the closing item is in the output register.
// Synchronous active-low reset; the store needs no clearing pass (written flags).
`include "assert_macros.svh"

module hit_window_readout_packer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [hwrp_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [hwrp_pkg::UPPER_W-1:0]  i_hit_upper,
    input  logic [hwrp_pkg::LOWER_W-1:0]  i_hit_lower,
    input  logic [hwrp_pkg::TIME_W-1:0]   i_window_start,
    input  logic [hwrp_pkg::TIME_W-1:0]   i_window_stop,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hwrp_pkg::TAG_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hwrp_pkg::WORD_W-1:0]   o_header_word,
    output logic [hwrp_pkg::WORD_W-1:0]   o_hit_word_a,
    output logic [hwrp_pkg::WORD_W-1:0]   o_hit_word_b,
    output logic [hwrp_pkg::WORD_W-1:0]   o_hit_word_c,
    output logic [hwrp_pkg::WORD_W-1:0]   o_hit_word_d,
    output logic                          o_last
);

    hwrp_pkg::t_state  r_state, n_state;
    hwrp_pkg::t_addr   r_addr, n_addr;
    hwrp_pkg::t_addr   r_start, n_start;
    hwrp_pkg::t_addr   r_stop, n_stop;
    hwrp_pkg::t_addr   r_rd_off, n_rd_off;
    logic              r_rd_vld, n_rd_vld;
    logic [hwrp_pkg::TAG_W-1:0] r_tag;

    logic                        r_out_vld;
    logic                        r_out_last;
    logic [hwrp_pkg::WORD_W-1:0] r_out_hdr, r_out_a, r_out_b, r_out_c, r_out_d;

    hwrp_pkg::t_store_req store_req;
    hwrp_pkg::t_hit       rd_data;
    logic                 rd_written;

    logic in_acc;
    logic can_load;
    logic rd_adv;
    logic walking;
    logic walk_more;
    logic rd_issue;
    logic load_hit;
    logic load_end;

    assign o_in_stall  = (r_state != hwrp_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign can_load  = !r_out_vld || !i_out_stall;
    assign rd_adv    = !r_rd_vld || can_load;
    assign walking   = (r_state == hwrp_pkg::S_WALK);
    assign walk_more = (r_state == hwrp_pkg::S_WALK) && (r_addr != r_stop);
    assign rd_issue  = walk_more && rd_adv;
    assign load_hit  = r_rd_vld && rd_written && (|rd_data) && can_load;
    assign load_end  = (r_state == hwrp_pkg::S_WALK) && (r_addr == r_stop)
                       && !r_rd_vld && can_load;

    always_comb begin
        store_req.wr_en   = in_acc && !i_action;
        store_req.wr_addr = hwrp_pkg::t_addr'(i_slot_index);
        store_req.rd_en   = rd_issue;
        store_req.rd_addr = r_addr;
    end

    hwrp_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (store_req),
        .i_wr_data   ({i_hit_upper, i_hit_lower}),
        .o_rd_data   (rd_data),
        .o_rd_written(rd_written)
    );

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_start  = r_start;
        n_stop   = r_stop;
        n_rd_off = r_rd_off;
        n_rd_vld = r_rd_vld && !rd_adv;
        case (r_state)
            hwrp_pkg::S_IDLE: begin
                if (in_acc && i_action) begin
                    n_start = i_window_start[hwrp_pkg::ADDR_BITS+1:2];
                    n_stop  = i_window_stop[hwrp_pkg::ADDR_BITS+1:2];
                    n_addr  = i_window_start[hwrp_pkg::ADDR_BITS+1:2];
                    n_state = hwrp_pkg::S_WALK;
                end
            end
            hwrp_pkg::S_WALK: begin
                if (rd_issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_off = r_addr - r_start;
                    n_addr   = r_addr + 1'b1;
                end
                if (load_end) begin
                    n_state = hwrp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hwrp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hwrp_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
            r_tag    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tag <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_start  <= n_start;
        r_stop   <= n_stop;
        r_rd_off <= n_rd_off;
    end

    // Output register: parts the walk from the downstream stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_hit || load_end) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_end) begin
            r_out_hdr  <= hwrp_pkg::END_WORD;
            r_out_a    <= hwrp_pkg::END_WORD;
            r_out_b    <= hwrp_pkg::END_WORD;
            r_out_c    <= hwrp_pkg::END_WORD;
            r_out_d    <= hwrp_pkg::END_WORD;
            r_out_last <= 1'b1;
        end else if (load_hit) begin
            r_out_hdr  <= {1'b1, r_tag[7:4], hwrp_pkg::OFF_W'(r_rd_off), 16'b0};
            r_out_a    <= {13'b0, rd_data[111:93]};
            r_out_b    <= {1'b0, rd_data[92:62]};
            r_out_c    <= {1'b0, rd_data[61:31]};
            r_out_d    <= {1'b0, rd_data[30:0]};
            r_out_last <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_header_word = r_out_hdr;
    assign o_hit_word_a  = r_out_a;
    assign o_hit_word_b  = r_out_b;
    assign o_hit_word_c  = r_out_c;
    assign o_hit_word_d  = r_out_d;
    assign o_last        = r_out_last;

    `ASSERT_NOW(a_idle_rd_empty, !walking, !r_rd_vld, "read stage busy while idle")
    `ASSERT_NOW(a_walk_ends_last, $fell(walking), o_out_valid && o_last, "no closing transaction")
    `ASSERT_NEXT(a_rd_hold, r_rd_vld && !rd_adv, r_rd_vld && $stable(rd_data), "read data lost")

endmodule

/* sv/hwrp_store.sv */
`include "assert_macros.svh"

module hwrp_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hwrp_pkg::t_store_req i_req,
    input  hwrp_pkg::t_hit      i_wr_data,
    output hwrp_pkg::t_hit      o_rd_data,
    output logic                o_rd_written
);

    hwrp_pkg::t_hit                   r_mem [hwrp_pkg::SLOT_COUNT];
    logic [hwrp_pkg::SLOT_COUNT-1:0]  r_written;
    hwrp_pkg::t_hit                   r_rd_data;
    logic                             r_rd_written;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = (32'(i_req.wr_addr) < hwrp_pkg::SLOT_COUNT);
    assign rd_in_range = (32'(i_req.rd_addr) < hwrp_pkg::SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_in_range) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Written flags stand in for the all-zero reset of the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en && wr_in_range) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= rd_in_range && r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_rd_written = r_rd_written;

    // Writes happen only between walks, so a read never meets a write.
    `ASSERT_NOW(a_no_rw_overlap, i_req.wr_en, !i_req.rd_en, "store read and write collide")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    typedef enum logic {
        ACT_WRITE   = 1'b0,
        ACT_TRIGGER = 1'b1
    } t_act;

    // How a directed row gets its expectation
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_CLOSE_ONLY,
        CHECK_HIT_AND_CLOSE
    } t_row_check;

    typedef struct packed {
        t_act                            action;
        logic [hwrp_pkg::SLOT_W-1:0]     slot;
        logic [hwrp_pkg::UPPER_W-1:0]    upper;
        logic [hwrp_pkg::LOWER_W-1:0]    lower;
        logic [hwrp_pkg::TIME_W-1:0]     start;
        logic [hwrp_pkg::TIME_W-1:0]     stop;
    } t_hit_txn;

    typedef struct packed {
        logic [hwrp_pkg::WORD_W-1:0] header;
        logic [hwrp_pkg::WORD_W-1:0] word_a;
        logic [hwrp_pkg::WORD_W-1:0] word_b;
        logic [hwrp_pkg::WORD_W-1:0] word_c;
        logic [hwrp_pkg::WORD_W-1:0] word_d;
        logic                        last;
    } t_packet;

    typedef struct packed {
        t_hit_txn   txn;
        t_row_check check;
        t_packet    typed_hit;
    } t_row;

    localparam t_packet CLOSING = '{hwrp_pkg::END_WORD, hwrp_pkg::END_WORD,
                                    hwrp_pkg::END_WORD, hwrp_pkg::END_WORD,
                                    hwrp_pkg::END_WORD, 1'b1};
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 66;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic                              i_action;
    logic [hwrp_pkg::SLOT_W-1:0]       i_slot_index;
    logic [hwrp_pkg::UPPER_W-1:0]      i_hit_upper;
    logic [hwrp_pkg::LOWER_W-1:0]      i_hit_lower;
    logic [hwrp_pkg::TIME_W-1:0]       i_window_start;
    logic [hwrp_pkg::TIME_W-1:0]       i_window_stop;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [hwrp_pkg::TAG_W-1:0]        i_cfg_data;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [hwrp_pkg::WORD_W-1:0]       o_header_word;
    logic [hwrp_pkg::WORD_W-1:0]       o_hit_word_a;
    logic [hwrp_pkg::WORD_W-1:0]       o_hit_word_b;
    logic [hwrp_pkg::WORD_W-1:0]       o_hit_word_c;
    logic [hwrp_pkg::WORD_W-1:0]       o_hit_word_d;
    logic                              o_last;

    // Predictor state
    logic [hwrp_pkg::HIT_W-1:0] slot_hits [hwrp_pkg::SLOT_COUNT];
    logic [hwrp_pkg::TAG_W-1:0] tag_setting;
    t_packet                    expected_packets [$];

    bit calm_phase;
    int error_count;
    int txn_count;
    int trigger_count;
    int packets_seen;
    int tag_writes;

    hit_window_readout_packer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_slot_index   (i_slot_index),
        .i_hit_upper    (i_hit_upper),
        .i_hit_lower    (i_hit_lower),
        .i_window_start (i_window_start),
        .i_window_stop  (i_window_stop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_header_word  (o_header_word),
        .o_hit_word_a   (o_hit_word_a),
        .o_hit_word_b   (o_hit_word_b),
        .o_hit_word_c   (o_hit_word_c),
        .o_hit_word_d   (o_hit_word_d),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t transaction %0d: %s", $time, packets_seen, msg);
    endtask

    // Store update for writes; window walk and expected transactions for triggers
    function automatic void pack_window(input t_hit_txn t);
        hwrp_pkg::t_addr            first;
        hwrp_pkg::t_addr            stop_slot;
        hwrp_pkg::t_addr            slot;
        hwrp_pkg::t_addr            offset;
        logic [hwrp_pkg::HIT_W-1:0] hit;
        t_packet                    p;
        if (t.action == ACT_WRITE) begin
            slot_hits[hwrp_pkg::t_addr'(t.slot)] = {t.upper, t.lower};
            return;
        end
        first     = t.start[hwrp_pkg::ADDR_BITS+1:2];
        stop_slot = t.stop[hwrp_pkg::ADDR_BITS+1:2];
        slot      = first;
        while (slot != stop_slot) begin
            hit = slot_hits[slot];
            if (hit != '0) begin
                offset   = slot - first;
                p.header = {1'b1, tag_setting[7:4], hwrp_pkg::OFF_W'(offset), 16'h0000};
                p.word_a = hwrp_pkg::WORD_W'(hit[111:93]);
                p.word_b = hwrp_pkg::WORD_W'(hit[92:62]);
                p.word_c = hwrp_pkg::WORD_W'(hit[61:31]);
                p.word_d = hwrp_pkg::WORD_W'(hit[30:0]);
                p.last   = 1'b0;
                expected_packets.push_back(p);
            end
            slot = slot + 1'b1;
        end
        expected_packets.push_back(CLOSING);
    endfunction

    function automatic t_hit_txn random_txn();
        t_hit_txn                   t;
        logic [hwrp_pkg::HIT_W-1:0] hit;
        hwrp_pkg::t_addr            span;
        t.action = ($urandom_range(99) < 55) ? ACT_WRITE : ACT_TRIGGER;
        t.slot   = hwrp_pkg::SLOT_W'($urandom);
        case ($urandom_range(9))
            0, 1:    hit = '0;
            2:       hit = '1;
            3, 4:    hit = hwrp_pkg::HIT_W'(1) << $urandom_range(hwrp_pkg::HIT_W - 1);
            default: hit = hwrp_pkg::HIT_W'({$urandom, $urandom, $urandom, $urandom});
        endcase
        t.upper = hit[111:64];
        t.lower = hit[63:0];
        t.start = hwrp_pkg::TIME_W'($urandom);
        case ($urandom_range(9))
            0:       span = '0;
            1:       span = '1;
            default: span = hwrp_pkg::t_addr'($urandom_range(1, hwrp_pkg::SLOT_COUNT - 1));
        endcase
        t.stop = hwrp_pkg::TIME_W'($urandom);
        t.stop[hwrp_pkg::ADDR_BITS+1:2] = t.start[hwrp_pkg::ADDR_BITS+1:2] + span;
        return t;
    endfunction

    task automatic send_txn(input t_hit_txn t);
        while (!calm_phase && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= t.action;
        i_slot_index   <= t.slot;
        i_hit_upper    <= t.upper;
        i_hit_lower    <= t.lower;
        i_window_start <= t.start;
        i_window_stop  <= t.stop;
        do @(posedge i_clk); while (o_in_stall);
        txn_count++;
        if (t.action == ACT_TRIGGER) trigger_count++;
    endtask

    // Hold input, let every expected transaction arrive, then give the walk time to finish
    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        while (expected_packets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tag(input logic [hwrp_pkg::TAG_W-1:0] tag);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tag;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tag_setting = tag;
        tag_writes++;
    endtask

    always @(posedge i_clk) begin : out_monitor
        t_packet got;
        t_packet want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_header_word, o_hit_word_a, o_hit_word_b, o_hit_word_c,
                        o_hit_word_d, o_last};
                if (expected_packets.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction %h", got));
                end else begin
                    want = expected_packets.pop_front();
                    if (got.header !== want.header)
                        report_mismatch($sformatf("header %h, want %h", got.header, want.header));
                    if (got.word_a !== want.word_a)
                        report_mismatch($sformatf("word_a %h, want %h", got.word_a, want.word_a));
                    if (got.word_b !== want.word_b)
                        report_mismatch($sformatf("word_b %h, want %h", got.word_b, want.word_b));
                    if (got.word_c !== want.word_c)
                        report_mismatch($sformatf("word_c %h, want %h", got.word_c, want.word_c));
                    if (got.word_d !== want.word_d)
                        report_mismatch($sformatf("word_d %h, want %h", got.word_d, want.word_d));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                end
                packets_seen++;
            end
            i_out_stall <= !calm_phase && ($urandom_range(99) < 22);
        end
    end

    initial begin : stimulus
        t_row                       directed_rows [$];
        logic [hwrp_pkg::TAG_W-1:0] phase_tags [5];
        t_hit_txn                   t;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= 1'b0;
        i_slot_index   <= '0;
        i_hit_upper    <= '0;
        i_hit_lower    <= '0;
        i_window_start <= '0;
        i_window_stop  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        foreach (slot_hits[k]) slot_hits[k] = '0;
        tag_setting = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store right after reset, then extremes, wrap and window edges
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd0, 11'd0},
                                  CHECK_CLOSE_ONLY, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd0, 11'h7FF},
                                  CHECK_CLOSE_ONLY, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd0, 48'hFFFF_FFFF_FFFF,
                                    64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 11'd0}, CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd0, 11'd4},
                                  CHECK_HIT_AND_CLOSE,
                                  '{32'h8000_0000, 32'h0007_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}});
        directed_rows.push_back('{'{ACT_WRITE, 6'd63, 48'h8000_0000_0000, 64'd0, 11'd0, 11'd0},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd62, 48'd0, 64'd1, 11'd0, 11'd0},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd1, 48'h0000_2000_0000,
                                    64'hC000_0000_8000_0000, 11'd0, 11'd0}, CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd251, 11'd9},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'h7FF, 11'h000},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd0, 48'd0, 64'd0, 11'd0, 11'd0},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd0, 11'h7FC},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd40, 48'hA5A5_5A5A_F00F,
                                    64'h0123_4567_89AB_CDEF, 11'd0, 11'd0}, CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'h4A0, 11'h0A7},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd63, 48'd0, 64'd0, 11'd0, 11'd0},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'd4, 11'd0},
                                  CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_WRITE, 6'd5, 48'h0000_0000_0001,
                                    64'h4000_0000_4000_0000, 11'd0, 11'd0}, CHECK_MODEL, '0});
        directed_rows.push_back('{'{ACT_TRIGGER, 6'd0, 48'd0, 64'd0, 11'h7F8, 11'h018},
                                  CHECK_MODEL, '0});

        foreach (directed_rows[r]) begin
            send_txn(directed_rows[r].txn);
            case (directed_rows[r].check)
                CHECK_MODEL: pack_window(directed_rows[r].txn);
                CHECK_HIT_AND_CLOSE: begin
                    expected_packets.push_back(directed_rows[r].typed_hit);
                    expected_packets.push_back(CLOSING);
                end
                default: expected_packets.push_back(CLOSING);
            endcase
        end

        phase_tags = '{8'hFF, 8'h0F, 8'hF0, 8'h00, 8'h00};
        phase_tags[3] = hwrp_pkg::TAG_W'($urandom_range(1, 254));
        for (int p = 0; p < 5; p++) begin
            settle_outputs();
            write_tag(phase_tags[p]);
            calm_phase = (p == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until the output side has caught up
                if (p == 3 && n == PHASE_ITEMS / 2) settle_outputs();
                t = random_txn();
                send_txn(t);
                pack_window(t);
            end
        end
        calm_phase = 1'b0;
        settle_outputs();

        $display("Ran %0d transactions (%0d window triggers, wrapped and empty included)",
                 txn_count, trigger_count);
        $display("Checked %0d readout transactions across %0d tag settings",
                 packets_seen, tag_writes);
        if (error_count == 0) begin
            $display("hit_window_readout_packer_top test passed");
        end else begin
            $display("hit_window_readout_packer_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d transactions still expected", expected_packets.size());
        $display("hit_window_readout_packer_top test failed");
        $finish;
    end

endmodule
